// File: rtl/rotation_matrix_to_quaternion_unit_assert.svh
// Assertion macros for the rotation matrix to quaternion unit.
`ifndef ROTATION_MATRIX_TO_QUATERNION_UNIT_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_UNIT_ASSERT_SVH

// Check a property on every clock outside reset.
`define RMQ_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Check that cons holds a fixed number of cycles after ante.
`define RMQ_ASSERT_LAT(label, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error("latency check failed");

`endif

// File: rtl/rmq_pkg.sv
package rmq_pkg;

  localparam int ROOT_W  = 16;
  localparam int RAD_W   = 32;
  localparam int REM_W   = 18;
  localparam int QUO_W   = 15;
  localparam int DIFF_W  = 17;
  localparam int LATENCY = 34;
  localparam logic [15:0] QONE = 16'd16384;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } branch_t;

  typedef struct packed {
    logic signed [15:0] r1c1;
    logic signed [15:0] r1c2;
    logic signed [15:0] r1c3;
    logic signed [15:0] r2c1;
    logic signed [15:0] r2c2;
    logic signed [15:0] r2c3;
    logic signed [15:0] r3c1;
    logic signed [15:0] r3c2;
    logic signed [15:0] r3c3;
  } matrix_t;

  typedef struct packed {
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic [1:0]         branch_taken;
    logic               degenerate;
  } quat_t;

  typedef struct packed {
    logic                      valid;
    branch_t                   branch;
    logic                      degen;
    logic signed [DIFF_W-1:0]  d0;
    logic signed [DIFF_W-1:0]  d1;
    logic signed [DIFF_W-1:0]  d2;
  } side_t;

  typedef struct packed {
    logic [ROOT_W-1:0] part;
    logic [QUO_W-1:0]  low;
    logic [QUO_W-1:0]  quo;
    logic              neg;
    logic              ovf;
  } div_t;

endpackage

// File: rtl/rmq_sqrt_cell.sv
module rmq_sqrt_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  rmq_pkg::side_t              side_in,
  input  logic [rmq_pkg::REM_W-1:0]   rem_in,
  input  logic [rmq_pkg::ROOT_W-1:0]  root_in,
  input  logic [rmq_pkg::RAD_W-1:0]   rad_in,
  output rmq_pkg::side_t              side_out,
  output logic [rmq_pkg::REM_W-1:0]   rem_out,
  output logic [rmq_pkg::ROOT_W-1:0]  root_out,
  output logic [rmq_pkg::RAD_W-1:0]   rad_out
);

  logic [rmq_pkg::REM_W+1:0] cand;
  logic [rmq_pkg::REM_W+1:0] trial_sub;
  logic [rmq_pkg::REM_W+1:0] trial;
  logic                      ge;

  always_comb begin
    cand      = {rem_in, rad_in[rmq_pkg::RAD_W-1 -: 2]};
    trial_sub = {2'b00, root_in, 2'b01};
    trial     = cand - trial_sub;
    ge        = (cand >= trial_sub);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      side_out.valid <= 1'b0;
    end else begin
      side_out <= side_in;
    end
    rem_out  <= ge ? trial[rmq_pkg::REM_W-1:0] : cand[rmq_pkg::REM_W-1:0];
    root_out <= {root_in[rmq_pkg::ROOT_W-2:0], ge};
    rad_out  <= {rad_in[rmq_pkg::RAD_W-3:0], 2'b00};
  end

endmodule

// File: rtl/rmq_div_cell.sv
module rmq_div_cell (
  input  logic                        clk,
  input  rmq_pkg::div_t               cur_in,
  input  logic [rmq_pkg::ROOT_W-1:0]  divisor_in,
  output rmq_pkg::div_t               cur_out,
  output logic [rmq_pkg::ROOT_W-1:0]  divisor_out
);

  logic [rmq_pkg::ROOT_W:0] t;
  logic [rmq_pkg::ROOT_W:0] dext;
  logic [rmq_pkg::ROOT_W:0] diff;
  logic                     ge;
  rmq_pkg::div_t            cur_next;

  always_comb begin
    t    = {cur_in.part, cur_in.low[rmq_pkg::QUO_W-1]};
    dext = {1'b0, divisor_in};
    diff = t - dext;
    ge   = (t >= dext);
    cur_next      = cur_in;
    cur_next.part = ge ? diff[rmq_pkg::ROOT_W-1:0] : t[rmq_pkg::ROOT_W-1:0];
    cur_next.low  = {cur_in.low[rmq_pkg::QUO_W-2:0], 1'b0};
    cur_next.quo  = {cur_in.quo[rmq_pkg::QUO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    cur_out     <= cur_next;
    divisor_out <= divisor_in;
  end

endmodule

// File: rtl/rotation_matrix_to_quaternion_unit.sv
// Throughput: one item per cycle; busy is always low.
// The rate is set by a 16-cell square root chain and three 15-cell divider chains,
// one root bit or quotient bit per cell, all fully pipelined.
// Reset clears all valid bits in the chains; in-flight items are dropped.
// The receiver cannot stall: done is a one-cycle strobe.
module rotation_matrix_to_quaternion_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  rmq_pkg::matrix_t matrix,
  output logic             done,
  output rmq_pkg::quat_t   result
);

  localparam int NSQ = rmq_pkg::ROOT_W;
  localparam int NDV = rmq_pkg::QUO_W;

  logic signed [18:0] m11, m12, m13, m21, m22, m23, m31, m32, m33;
  logic signed [18:0] trace, rad;
  rmq_pkg::side_t     prep;
  logic               degen;
  logic [16:0]        rad_u;

  assign busy = 1'b0;

  always_comb begin
    m11 = 19'(matrix.r1c1); m12 = 19'(matrix.r1c2); m13 = 19'(matrix.r1c3);
    m21 = 19'(matrix.r2c1); m22 = 19'(matrix.r2c2); m23 = 19'(matrix.r2c3);
    m31 = 19'(matrix.r3c1); m32 = 19'(matrix.r3c2); m33 = 19'(matrix.r3c3);
    trace = m11 + m22 + m33;
    prep.valid = start;
    if (trace > 0) begin
      prep.branch = rmq_pkg::BR_TRACE;
      rad     = 19'sd16384 + trace;
      prep.d0 = 17'(m32 - m23);
      prep.d1 = 17'(m13 - m31);
      prep.d2 = 17'(m21 - m12);
    end else if (m11 > m22 && m11 > m33) begin
      prep.branch = rmq_pkg::BR_X;
      rad     = 19'sd16384 + m11 - m22 - m33;
      prep.d0 = 17'(m12 + m21);
      prep.d1 = 17'(m13 + m31);
      prep.d2 = 17'(m32 - m23);
    end else if (m22 > m33) begin
      prep.branch = rmq_pkg::BR_Y;
      rad     = 19'sd16384 + m22 - m11 - m33;
      prep.d0 = 17'(m12 + m21);
      prep.d1 = 17'(m23 + m32);
      prep.d2 = 17'(m13 - m31);
    end else begin
      prep.branch = rmq_pkg::BR_Z;
      rad     = 19'sd16384 + m33 - m11 - m22;
      prep.d0 = 17'(m13 + m31);
      prep.d1 = 17'(m23 + m32);
      prep.d2 = 17'(m21 - m12);
    end
    degen      = (rad <= 0);
    prep.degen = degen;
    rad_u      = degen ? 17'd0 : rad[16:0];
  end

  // square root chain
  rmq_pkg::side_t                side_s [0:NSQ];
  logic [rmq_pkg::REM_W-1:0]     rem_s  [0:NSQ];
  logic [rmq_pkg::ROOT_W-1:0]    root_s [0:NSQ];
  logic [rmq_pkg::RAD_W-1:0]     rad_s  [0:NSQ];

  always_ff @(posedge clk) begin
    if (rst) begin
      side_s[0].valid <= 1'b0;
    end else begin
      side_s[0] <= prep;
    end
    rad_s[0] <= {1'b0, rad_u, 14'd0};
  end

  assign rem_s[0]  = '0;
  assign root_s[0] = '0;

  for (genvar i = 0; i < NSQ; i++) begin : g_sqrt
    rmq_sqrt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .side_in  (side_s[i]),
      .rem_in   (rem_s[i]),
      .root_in  (root_s[i]),
      .rad_in   (rad_s[i]),
      .side_out (side_s[i+1]),
      .rem_out  (rem_s[i+1]),
      .root_out (root_s[i+1]),
      .rad_out  (rad_s[i+1])
    );
  end

  // divider setup
  rmq_pkg::side_t              side_d [0:NDV];
  logic [15:0]                 main_d [0:NDV];
  rmq_pkg::div_t               cur_d  [0:2][0:NDV];
  logic [rmq_pkg::ROOT_W-1:0]  dvs_d  [0:2][0:NDV];
  logic signed [rmq_pkg::DIFF_W-1:0] dsel [0:2];

  assign dsel[0] = side_s[NSQ].d0;
  assign dsel[1] = side_s[NSQ].d1;
  assign dsel[2] = side_s[NSQ].d2;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_d[0].valid <= 1'b0;
    end else begin
      side_d[0] <= side_s[NSQ];
    end
    main_d[0] <= {1'b0, root_s[NSQ][rmq_pkg::ROOT_W-1:1]};
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [rmq_pkg::DIFF_W-1:0] mag;
    rmq_pkg::div_t              init;

    always_comb begin
      mag       = dsel[l][rmq_pkg::DIFF_W-1] ? rmq_pkg::DIFF_W'(-dsel[l])
                                             : rmq_pkg::DIFF_W'(dsel[l]);
      init.part = {1'b0, mag[16:2]};
      init.low  = {mag[1:0], 13'd0};
      init.quo  = '0;
      init.neg  = dsel[l][rmq_pkg::DIFF_W-1];
      init.ovf  = ({1'b0, mag[16:2]} >= root_s[NSQ]);
    end

    always_ff @(posedge clk) begin
      cur_d[l][0] <= init;
      dvs_d[l][0] <= root_s[NSQ];
    end

    for (genvar k = 0; k < NDV; k++) begin : g_cell
      rmq_div_cell u_cell (
        .clk         (clk),
        .cur_in      (cur_d[l][k]),
        .divisor_in  (dvs_d[l][k]),
        .cur_out     (cur_d[l][k+1]),
        .divisor_out (dvs_d[l][k+1])
      );
    end
  end

  for (genvar k = 0; k < NDV; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        side_d[k+1].valid <= 1'b0;
      end else begin
        side_d[k+1] <= side_d[k];
      end
      main_d[k+1] <= main_d[k];
    end
  end

  // assemble
  logic signed [15:0] comp [0:2];
  logic signed [15:0] main_sat;
  rmq_pkg::quat_t     res_next;
  rmq_pkg::side_t     fin;

  always_comb begin
    fin = side_d[NDV];
    for (int l = 0; l < 3; l++) begin
      logic [15:0] m;
      m = (cur_d[l][NDV].ovf || {1'b0, cur_d[l][NDV].quo} > rmq_pkg::QONE)
          ? rmq_pkg::QONE : {1'b0, cur_d[l][NDV].quo};
      comp[l] = cur_d[l][NDV].neg ? -$signed(m) : $signed(m);
    end
    main_sat = (main_d[NDV] > rmq_pkg::QONE) ? $signed(rmq_pkg::QONE)
                                             : $signed(main_d[NDV]);
    res_next.branch_taken = fin.branch;
    res_next.degenerate   = fin.degen;
    case (fin.branch)
      rmq_pkg::BR_TRACE: begin
        res_next.quat_x = comp[0]; res_next.quat_y = comp[1];
        res_next.quat_z = comp[2]; res_next.quat_w = main_sat;
      end
      rmq_pkg::BR_X: begin
        res_next.quat_x = main_sat; res_next.quat_y = comp[0];
        res_next.quat_z = comp[1];  res_next.quat_w = comp[2];
      end
      rmq_pkg::BR_Y: begin
        res_next.quat_x = comp[0];  res_next.quat_y = main_sat;
        res_next.quat_z = comp[1];  res_next.quat_w = comp[2];
      end
      default: begin
        res_next.quat_x = comp[0];  res_next.quat_y = comp[1];
        res_next.quat_z = main_sat; res_next.quat_w = comp[2];
      end
    endcase
    if (fin.degen) begin
      res_next.quat_x = '0; res_next.quat_y = '0;
      res_next.quat_z = '0; res_next.quat_w = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin.valid;
    end
    result <= res_next;
  end

endmodule

// File: rtl/rmq_checker.sv
`include "rotation_matrix_to_quaternion_unit_assert.svh"

module rmq_checker (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input rmq_pkg::quat_t result
);

  logic quat_zero;

  assign quat_zero = (result.quat_x == 16'sd0) && (result.quat_y == 16'sd0) &&
                     (result.quat_z == 16'sd0) && (result.quat_w == 16'sd0);

  `RMQ_ASSERT(a_never_busy, !busy)
  `RMQ_ASSERT_LAT(a_latency_hit, start, 34, done)
  `RMQ_ASSERT_LAT(a_latency_miss, !start, 34, !done)
  `RMQ_ASSERT(a_degen_zero, (done && result.degenerate) |-> quat_zero)

endmodule

bind rotation_matrix_to_quaternion_unit rmq_checker u_rmq_checker (.*);

// File: dv/rotation_matrix_to_quaternion_unit_tb.sv
module rotation_matrix_to_quaternion_unit_tb;
  import rmq_pkg::*;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  matrix_t matrix = '0;
  logic    done;
  quat_t   result;

  always #10 clk = ~clk;

  rotation_matrix_to_quaternion_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .matrix(matrix), .done(done), .result(result)
  );

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint clamp_one(longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  function automatic longint scaled_quot(longint d, longint unsigned rt);
    longint unsigned mag;
    longint q;
    mag = (d < 0 ? -d : d) * 8192;
    q = longint'(mag / rt);
    return clamp_one(d < 0 ? -q : q);
  endfunction

  function automatic quat_t matrix_to_quat(matrix_t m);
    longint a11, a12, a13, a21, a22, a23, a31, a32, a33, tr, rad;
    longint dx, dy, dz, dw, mc;
    longint unsigned rt;
    branch_t br;
    quat_t q;
    a11 = longint'(m.r1c1); a12 = longint'(m.r1c2); a13 = longint'(m.r1c3);
    a21 = longint'(m.r2c1); a22 = longint'(m.r2c2); a23 = longint'(m.r2c3);
    a31 = longint'(m.r3c1); a32 = longint'(m.r3c2); a33 = longint'(m.r3c3);
    tr = a11 + a22 + a33;
    dx = 0; dy = 0; dz = 0; dw = 0;
    if (tr > 0) begin
      br = BR_TRACE; rad = 16384 + tr;
      dx = a32 - a23; dy = a13 - a31; dz = a21 - a12;
    end else if (a11 > a22 && a11 > a33) begin
      br = BR_X; rad = 16384 + a11 - a22 - a33;
      dw = a32 - a23; dy = a12 + a21; dz = a13 + a31;
    end else if (a22 > a33) begin
      br = BR_Y; rad = 16384 + a22 - a11 - a33;
      dw = a13 - a31; dx = a12 + a21; dz = a23 + a32;
    end else begin
      br = BR_Z; rad = 16384 + a33 - a11 - a22;
      dw = a21 - a12; dx = a13 + a31; dy = a23 + a32;
    end
    q = '0;
    q.branch_taken = br;
    if (rad <= 0) begin
      q.degenerate = 1'b1;
    end else begin
      rt = int_sqrt(longint'(rad) << 14);
      mc = clamp_one(longint'(int_sqrt(longint'(rad) << 12)));
      q.quat_x = 16'((br == BR_X) ? mc : scaled_quot(dx, rt));
      q.quat_y = 16'((br == BR_Y) ? mc : scaled_quot(dy, rt));
      q.quat_z = 16'((br == BR_Z) ? mc : scaled_quot(dz, rt));
      q.quat_w = 16'((br == BR_TRACE) ? mc : scaled_quot(dw, rt));
    end
    return q;
  endfunction

  class quat_scoreboard;
    quat_t pending[$];
    int    errors;
    int    checked;
    int    branch_seen[4];
    int    degen_seen;

    function void note_matrix(matrix_t m);
      pending.push_back(matrix_to_quat(m));
    endfunction

    function void check_quat(quat_t got);
      quat_t want;
      if (pending.size() == 0) begin
        $error("unexpected result %h", got);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      branch_seen[want.branch_taken]++;
      if (want.degenerate) degen_seen++;
      if (got.quat_x !== want.quat_x) begin
        $error("quat_x: expected %0d, got %0d", want.quat_x, got.quat_x); errors++;
      end
      if (got.quat_y !== want.quat_y) begin
        $error("quat_y: expected %0d, got %0d", want.quat_y, got.quat_y); errors++;
      end
      if (got.quat_z !== want.quat_z) begin
        $error("quat_z: expected %0d, got %0d", want.quat_z, got.quat_z); errors++;
      end
      if (got.quat_w !== want.quat_w) begin
        $error("quat_w: expected %0d, got %0d", want.quat_w, got.quat_w); errors++;
      end
      if (got.branch_taken !== want.branch_taken) begin
        $error("branch_taken: expected %0d, got %0d", want.branch_taken,
               got.branch_taken);
        errors++;
      end
      if (got.degenerate !== want.degenerate) begin
        $error("degenerate: expected %0d, got %0d", want.degenerate, got.degenerate);
        errors++;
      end
    endfunction
  endclass

  quat_scoreboard board = new();

  always @(posedge clk) begin
    if (!rst && done) board.check_quat(result);
  end

  function automatic logic signed [15:0] rand_entry();
    int unsigned k;
    k = $urandom_range(0, 15);
    if (k == 0) return 16'($urandom());
    if (k == 1) return 16'sd16384;
    if (k == 2) return -16'sd16384;
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic logic signed [15:0] to_q(real v);
    return 16'($rtoi(v * 16384.0));
  endfunction

  // rotation from a random axis-angle pair, so every branch is reached
  function automatic matrix_t rand_rotation();
    real ax, ay, az, n, th, c, s, t;
    matrix_t m;
    ax = $urandom_range(0, 2000) - 1000.0;
    ay = $urandom_range(0, 2000) - 1000.0;
    az = $urandom_range(0, 2000) - 1000.0;
    n = $sqrt(ax * ax + ay * ay + az * az);
    if (n < 1.0) begin
      ax = 1.0; n = 1.0;
    end
    ax = ax / n; ay = ay / n; az = az / n;
    th = $urandom_range(0, 62831) / 10000.0;
    c = $cos(th); s = $sin(th); t = 1.0 - c;
    m.r1c1 = to_q(t * ax * ax + c);
    m.r1c2 = to_q(t * ax * ay - s * az);
    m.r1c3 = to_q(t * ax * az + s * ay);
    m.r2c1 = to_q(t * ax * ay + s * az);
    m.r2c2 = to_q(t * ay * ay + c);
    m.r2c3 = to_q(t * ay * az - s * ax);
    m.r3c1 = to_q(t * ax * az - s * ay);
    m.r3c2 = to_q(t * ay * az + s * ax);
    m.r3c3 = to_q(t * az * az + c);
    return m;
  endfunction

  function automatic matrix_t rand_matrix();
    matrix_t m;
    m.r1c1 = rand_entry(); m.r1c2 = rand_entry(); m.r1c3 = rand_entry();
    m.r2c1 = rand_entry(); m.r2c2 = rand_entry(); m.r2c3 = rand_entry();
    m.r3c1 = rand_entry(); m.r3c2 = rand_entry(); m.r3c3 = rand_entry();
    return m;
  endfunction

  task automatic send_matrix(matrix_t m);
    matrix <= m;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    board.note_matrix(m);
    @(negedge clk);
  endtask

  task automatic idle_gap();
    int unsigned k;
    int unsigned n;
    k = $urandom_range(0, 19);
    if (k < 10) return;
    n = (k < 18) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
  endtask

  function automatic matrix_t diag(int a, int b, int c);
    matrix_t m;
    m = '0;
    m.r1c1 = 16'(a); m.r2c2 = 16'(b); m.r3c3 = 16'(c);
    return m;
  endfunction

  initial begin
    matrix_t m;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_matrix(diag(16384, 16384, 16384));
    send_matrix(diag(16384, -16384, -16384));
    send_matrix(diag(-16384, 16384, -16384));
    send_matrix(diag(-16384, -16384, 16384));
    send_matrix(diag(-16384, -16384, -16384));
    send_matrix(diag(0, 0, 0));
    send_matrix(diag(-8192, -8192, -8192));
    send_matrix(diag(-100, -100, -200));
    send_matrix(diag(-200, -100, -100));
    send_matrix(diag(0, -16384, 0));
    send_matrix(diag(-16384, 0, 16384));
    send_matrix(diag(16384, 16384, -16384));
    m = '1;
    send_matrix(m);
    m = {9{16'h7fff}};
    send_matrix(m);
    m = {9{16'h8000}};
    send_matrix(m);
    m = {9{16'h5555}};
    send_matrix(m);
    m = {9{16'haaaa}};
    send_matrix(m);
    m = diag(-16384, -16384, 16384);
    m.r1c2 = 16'sd16384; m.r2c1 = 16'sd16384; m.r1c3 = 16'sd16384; m.r3c1 = -16'sd16384;
    send_matrix(m);
    m = diag(1, 1, 1);
    m.r3c2 = 16'sh7fff; m.r2c3 = 16'sh8000;
    send_matrix(m);
    drain();

    for (int i = 0; i < 700; i++) begin
      if ($urandom_range(0, 3) != 0) send_matrix(rand_rotation());
      else send_matrix(rand_matrix());
      if (i == 350) drain();
      else if (i < 200 || i > 500) idle_gap();
    end
    drain();
    repeat (LATENCY + 10) @(negedge clk);

    $display("checked %0d quaternions; branches trace/x/y/z = %0d/%0d/%0d/%0d",
             board.checked, board.branch_seen[0], board.branch_seen[1],
             board.branch_seen[2], board.branch_seen[3]);
    $display("degenerate radicands seen: %0d", board.degen_seen);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("rotation_matrix_to_quaternion_unit_tb: clean");
    end else begin
      $display("rotation_matrix_to_quaternion_unit_tb: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("rotation_matrix_to_quaternion_unit_tb: errors");
    $finish;
  end
endmodule
